// File: design/numlit_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and widths of the numeric literal parser.
package numlit_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int OUT_WIDTH   = 64;
   localparam int MAG_WIDTH   = VALUE_WIDTH - 1;
   localparam int SUM_WIDTH   = MAG_WIDTH + 4;
   localparam logic [MAG_WIDTH-1:0] MAX_MAG = {MAG_WIDTH{1'b1}};

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UB    = 8'h42;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LB    = 8'h62;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] LETTER_BASE = 8'd10;

   typedef enum logic [3:0] {
      PH_START    = 4'b0001,
      PH_SIGNED   = 4'b0010,
      PH_LEADZERO = 4'b0100,
      PH_BODY     = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_BIN = 2'd2
   } radix_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] value;
      logic [1:0]                  radix;
      logic                        valid_res;
      logic                        overflow;
   } rsp_type;

   typedef struct packed {
      phase_type             phase;
      logic                  negative;
      radix_type             base_sel;
      logic [MAG_WIDTH-1:0]  magnitude;
      logic                  digit_seen;
      logic                  bad_char;
      logic                  ovf_seen;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      phase:      PH_START,
      negative:   1'b0,
      base_sel:   RADIX_DEC,
      magnitude:  '0,
      digit_seen: 1'b0,
      bad_char:   1'b0,
      ovf_seen:   1'b0
   };

endpackage

// File: design/numeric_literal_parser_unit.sv
`timescale 1ns / 1ps
// Top level of the numeric literal parser: input register, token state and result register.
//
// The block reads an assembler numeric token one character per input word on
// the req_ channel; req_data.last marks the final character. Each token is an
// optional sign, then decimal digits, or a 0x/0X prefix with hex digits, or a
// 0b/0B prefix with binary digits. At the final character one result word
// leaves on the rsp_ channel with the signed value, the radix, a validity flag
// and an overflow flag; other characters give no result.
// A character is held in the input register and then folded into the token
// state by one shift-add and compare; for a final character the result register
// is loaded at that same edge. One character is taken in every clock cycle
// while no final character is stalled. If the result register is still full
// and the receiver holds rsp_ready low, a final character waits in the input
// register and req_ready drops; other characters keep flowing. Synchronous
// reset empties both registers and puts the parser at the start of a new token.
module numeric_literal_parser_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  numlit_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output numlit_pkg::rsp_type rsp_data
);

   logic                        in_valid_ff;
   logic                        in_valid_in;
   numlit_pkg::req_type         in_word_ff;
   numlit_pkg::parse_state_type state_ff;
   numlit_pkg::parse_state_type state_in;
   numlit_pkg::parse_state_type step_state;
   numlit_pkg::rsp_type         step_result;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   numlit_pkg::rsp_type         rsp_word_ff;
   logic                        advance;
   logic                        req_take;

   numlit_step u_step (
      .cur_state (state_ff),
      .req_word  (in_word_ff),
      .nxt_state (step_state),
      .result    (step_result)
   );

   assign advance   = in_valid_ff && (!in_word_ff.last || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      state_in = state_ff;
      if (advance) begin
         state_in = in_word_ff.last ? numlit_pkg::STATE_RESET : step_state;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance && in_word_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= numlit_pkg::STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_data;
      end
      if (advance && in_word_ff.last) begin
         rsp_word_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

endmodule

// File: design/numlit_step.sv
`timescale 1ns / 1ps
// Next-state and result logic for one character of a numeric token.
module numlit_step (
   input  numlit_pkg::parse_state_type cur_state,
   input  numlit_pkg::req_type         req_word,
   output numlit_pkg::parse_state_type nxt_state,
   output numlit_pkg::rsp_type         result
);

   logic [7:0]                       ch;
   logic                             take_first;
   logic                             take_body;
   logic [7:0]                       offset;
   logic [3:0]                       digit;
   logic                             is_hex_char;
   logic                             digit_ok;
   logic [numlit_pkg::SUM_WIDTH-1:0] mag_ext;
   logic [numlit_pkg::SUM_WIDTH-1:0] sum;
   logic [numlit_pkg::VALUE_WIDTH-1:0] mag_w;
   logic [numlit_pkg::VALUE_WIDTH-1:0] signed_mag;
   logic                             good;

   assign ch = req_word.ch;

   always_comb begin
      offset      = ch - numlit_pkg::CH_ZERO;
      is_hex_char = 1'b1;
      if (ch inside {[numlit_pkg::CH_ZERO:numlit_pkg::CH_NINE]}) begin
         offset = ch - numlit_pkg::CH_ZERO;
      end else if (ch inside {[numlit_pkg::CH_LA:numlit_pkg::CH_LF]}) begin
         offset = ch - numlit_pkg::CH_LA + numlit_pkg::LETTER_BASE;
      end else if (ch inside {[numlit_pkg::CH_UA:numlit_pkg::CH_UF]}) begin
         offset = ch - numlit_pkg::CH_UA + numlit_pkg::LETTER_BASE;
      end else begin
         is_hex_char = 1'b0;
      end
      digit = offset[3:0];
   end

   always_comb begin
      nxt_state  = cur_state;
      take_first = 1'b0;
      take_body  = 1'b0;
      digit_ok   = 1'b0;
      mag_ext    = numlit_pkg::SUM_WIDTH'(cur_state.magnitude);
      sum        = '0;

      case (cur_state.phase)
         numlit_pkg::PH_START: begin
            if (ch == numlit_pkg::CH_PLUS) begin
               nxt_state.phase = numlit_pkg::PH_SIGNED;
            end else if (ch == numlit_pkg::CH_MINUS) begin
               nxt_state.negative = 1'b1;
               nxt_state.phase    = numlit_pkg::PH_SIGNED;
            end else begin
               take_first = 1'b1;
            end
         end
         numlit_pkg::PH_SIGNED: begin
            take_first = 1'b1;
         end
         numlit_pkg::PH_LEADZERO: begin
            nxt_state.phase = numlit_pkg::PH_BODY;
            if (ch == numlit_pkg::CH_LX || ch == numlit_pkg::CH_UX) begin
               nxt_state.base_sel   = numlit_pkg::RADIX_HEX;
               nxt_state.digit_seen = 1'b0;
            end else if (ch == numlit_pkg::CH_LB || ch == numlit_pkg::CH_UB) begin
               nxt_state.base_sel   = numlit_pkg::RADIX_BIN;
               nxt_state.digit_seen = 1'b0;
            end else begin
               nxt_state.base_sel = numlit_pkg::RADIX_DEC;
               take_body          = 1'b1;
            end
         end
         default: begin
            nxt_state.phase = numlit_pkg::PH_BODY;
            take_body       = 1'b1;
         end
      endcase

      if (take_first) begin
         if (ch == numlit_pkg::CH_ZERO) begin
            nxt_state.digit_seen = 1'b1;
            nxt_state.magnitude  = '0;
            nxt_state.phase      = numlit_pkg::PH_LEADZERO;
         end else begin
            nxt_state.phase    = numlit_pkg::PH_BODY;
            nxt_state.base_sel = numlit_pkg::RADIX_DEC;
            take_body          = 1'b1;
         end
      end

      case (nxt_state.base_sel)
         numlit_pkg::RADIX_HEX: begin
            digit_ok = is_hex_char;
            sum      = (mag_ext << 4) + numlit_pkg::SUM_WIDTH'(digit);
         end
         numlit_pkg::RADIX_BIN: begin
            digit_ok = ch inside {[numlit_pkg::CH_ZERO:numlit_pkg::CH_ONE]};
            sum      = (mag_ext << 1) + numlit_pkg::SUM_WIDTH'(digit);
         end
         default: begin
            digit_ok = ch inside {[numlit_pkg::CH_ZERO:numlit_pkg::CH_NINE]};
            sum      = (mag_ext << 3) + (mag_ext << 1) + numlit_pkg::SUM_WIDTH'(digit);
         end
      endcase

      if (take_body) begin
         if (!digit_ok) begin
            nxt_state.bad_char = 1'b1;
         end else begin
            nxt_state.digit_seen = 1'b1;
            if (!cur_state.ovf_seen) begin
               if (sum > numlit_pkg::SUM_WIDTH'(numlit_pkg::MAX_MAG)) begin
                  nxt_state.ovf_seen  = 1'b1;
                  nxt_state.magnitude = numlit_pkg::MAX_MAG;
               end else begin
                  nxt_state.magnitude = sum[numlit_pkg::MAG_WIDTH-1:0];
               end
            end
         end
      end
   end

   always_comb begin
      good       = nxt_state.digit_seen && !nxt_state.bad_char;
      mag_w      = numlit_pkg::VALUE_WIDTH'(nxt_state.magnitude);
      signed_mag = nxt_state.negative ? (~mag_w + 1'b1) : mag_w;
      result.value     = good ? numlit_pkg::OUT_WIDTH'(signed'(signed_mag)) : '0;
      result.radix     = nxt_state.base_sel;
      result.valid_res = good;
      result.overflow  = good && nxt_state.ovf_seen;
   end

endmodule

// File: design/numlit_checker.sv
`timescale 1ns / 1ps
// Port checker for the numeric literal parser and its bind to the top level.
module numlit_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input numlit_pkg::rsp_type rsp_data
);

   // A stalled result word stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed or dropped while stalled");

   // An invalid token carries a zero value and no overflow.
   a_invalid_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.valid_res |-> rsp_data.value == '0 && !rsp_data.overflow)
      else $error("invalid token with non-zero value or overflow");

   // The radix code is never the unused fourth code.
   a_radix_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.radix != 2'd3)
      else $error("result radix out of range");

   // A freshly reset block offers no result word.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered straight after reset");

endmodule

bind numeric_literal_parser_unit numlit_checker u_checker (.*);

// File: bench/tb_numeric_literal_parser_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for the numeric literal parser: feeds tokens and checks every result word.
module tb_numeric_literal_parser_unit;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int MAX_WAIT      = 14;
   localparam logic [4:0] NOT_DIGIT = 5'd16;

   typedef logic [7:0] char_queue_type[$];

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   numlit_pkg::req_type req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   numlit_pkg::rsp_type rsp_data;

   numeric_literal_parser_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   numlit_pkg::phase_type p_phase;
   logic                  p_negative;
   numlit_pkg::radix_type p_base;
   logic [63:0]           p_mag;
   logic                  p_digit;
   logic                  p_bad;
   logic                  p_ovf;

   numlit_pkg::rsp_type expected_results[$];
   char_queue_type      token_buf;
   bit          no_idle        = 1'b0;
   int          fail_count     = 0;
   int          chars_sent     = 0;
   int          tokens_sent    = 0;
   int          results_checked = 0;
   int          saturated_seen = 0;
   int          cycle_count    = 0;
   int          hold_cycles    = 0;

   function automatic int draw_wait();
      if (no_idle || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic void clear_parse_state();
      p_phase    = numlit_pkg::PH_START;
      p_negative = 1'b0;
      p_base     = numlit_pkg::RADIX_DEC;
      p_mag      = '0;
      p_digit    = 1'b0;
      p_bad      = 1'b0;
      p_ovf      = 1'b0;
   endfunction

   function automatic logic [4:0] digit_value(input logic [7:0] c,
                                              input numlit_pkg::radix_type r);
      logic [4:0] d;
      d = NOT_DIGIT;
      if (c >= numlit_pkg::CH_ZERO && c <= numlit_pkg::CH_NINE)
         d = 5'(c - numlit_pkg::CH_ZERO);
      else if (c >= numlit_pkg::CH_LA && c <= numlit_pkg::CH_LF)
         d = 5'(c - numlit_pkg::CH_LA + numlit_pkg::LETTER_BASE);
      else if (c >= numlit_pkg::CH_UA && c <= numlit_pkg::CH_UF)
         d = 5'(c - numlit_pkg::CH_UA + numlit_pkg::LETTER_BASE);
      if (r == numlit_pkg::RADIX_BIN && d > 5'd1) d = NOT_DIGIT;
      else if (r == numlit_pkg::RADIX_DEC && d > 5'd9) d = NOT_DIGIT;
      return d;
   endfunction

   function automatic void add_digit(input logic [4:0] d);
      logic [63:0] lim;
      logic [63:0] base;
      lim  = {1'b0, numlit_pkg::MAX_MAG};
      base = (p_base == numlit_pkg::RADIX_HEX) ? 64'd16 :
             (p_base == numlit_pkg::RADIX_BIN) ? 64'd2 : 64'd10;
      p_digit = 1'b1;
      if (!p_ovf) begin
         if (p_mag > (lim - 64'(d)) / base) begin
            p_ovf = 1'b1;
            p_mag = lim;
         end else begin
            p_mag = p_mag * base + 64'(d);
         end
      end
   endfunction

   function automatic void take_body(input logic [7:0] c);
      logic [4:0] d;
      d = digit_value(c, p_base);
      if (d == NOT_DIGIT) p_bad = 1'b1;
      else add_digit(d);
   endfunction

   function automatic void take_first(input logic [7:0] c);
      if (c == numlit_pkg::CH_ZERO) begin
         p_digit = 1'b1;
         p_mag   = '0;
         p_phase = numlit_pkg::PH_LEADZERO;
      end else begin
         p_phase = numlit_pkg::PH_BODY;
         p_base  = numlit_pkg::RADIX_DEC;
         take_body(c);
      end
   endfunction

   function automatic bit predict_char(input logic [7:0] c, input logic fin,
                                       output numlit_pkg::rsp_type res);
      logic ok;
      res = '0;
      case (p_phase)
         numlit_pkg::PH_START: begin
            if (c == numlit_pkg::CH_PLUS) begin
               p_phase = numlit_pkg::PH_SIGNED;
            end else if (c == numlit_pkg::CH_MINUS) begin
               p_negative = 1'b1;
               p_phase    = numlit_pkg::PH_SIGNED;
            end else begin
               take_first(c);
            end
         end
         numlit_pkg::PH_SIGNED: take_first(c);
         numlit_pkg::PH_LEADZERO: begin
            p_phase = numlit_pkg::PH_BODY;
            if (c == numlit_pkg::CH_LX || c == numlit_pkg::CH_UX) begin
               p_base  = numlit_pkg::RADIX_HEX;
               p_digit = 1'b0;
            end else if (c == numlit_pkg::CH_LB || c == numlit_pkg::CH_UB) begin
               p_base  = numlit_pkg::RADIX_BIN;
               p_digit = 1'b0;
            end else begin
               p_base = numlit_pkg::RADIX_DEC;
               take_body(c);
            end
         end
         default: take_body(c);
      endcase
      if (!fin) return 1'b0;
      ok            = p_digit && !p_bad;
      res.value     = ok ? (p_negative ? 64'd0 - p_mag : p_mag) : 64'd0;
      res.radix     = p_base;
      res.valid_res = ok;
      res.overflow  = ok && p_ovf;
      clear_parse_state();
      return 1'b1;
   endfunction

   task automatic send_char(input logic [7:0] c, input logic fin);
      int                  gap;
      numlit_pkg::rsp_type res;
      gap = draw_wait();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{ch: c, last: fin};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
      if (predict_char(c, fin, res)) begin
         expected_results.push_back(res);
         tokens_sent++;
      end
   endtask

   task automatic send_buffer();
      for (int i = 0; i < token_buf.size(); i++)
         send_char(token_buf[i], i == token_buf.size() - 1);
   endtask

   task automatic send_text(input string s);
      token_buf.delete();
      for (int i = 0; i < s.len(); i++) token_buf.push_back(s[i]);
      send_buffer();
   endtask

   function automatic logic [7:0] random_digit(input numlit_pkg::radix_type r);
      int v;
      if (r == numlit_pkg::RADIX_BIN) return 8'(numlit_pkg::CH_ZERO + $urandom_range(0, 1));
      if (r == numlit_pkg::RADIX_DEC) return 8'(numlit_pkg::CH_ZERO + $urandom_range(0, 9));
      v = $urandom_range(0, 15);
      if (v < 10) return 8'(numlit_pkg::CH_ZERO + v);
      return 8'(($urandom_range(0, 1) ? numlit_pkg::CH_LA : numlit_pkg::CH_UA) + v - 10);
   endfunction

   function automatic void build_random_token();
      numlit_pkg::radix_type r;
      int        sign_pick;
      int        flaw;
      int        ndig;
      int        pos;
      token_buf.delete();
      sign_pick = $urandom_range(0, 3);
      flaw      = $urandom_range(0, 7);
      r         = numlit_pkg::radix_type'($urandom_range(0, 2));
      if (sign_pick == 2) token_buf.push_back(numlit_pkg::CH_PLUS);
      if (sign_pick == 3) token_buf.push_back(numlit_pkg::CH_MINUS);
      if (r == numlit_pkg::RADIX_HEX) begin
         token_buf.push_back(numlit_pkg::CH_ZERO);
         token_buf.push_back($urandom_range(0, 1) ? numlit_pkg::CH_LX : numlit_pkg::CH_UX);
      end else if (r == numlit_pkg::RADIX_BIN) begin
         token_buf.push_back(numlit_pkg::CH_ZERO);
         token_buf.push_back($urandom_range(0, 1) ? numlit_pkg::CH_LB : numlit_pkg::CH_UB);
      end
      if ($urandom_range(0, 9) == 0)
         ndig = (r == numlit_pkg::RADIX_BIN) ? $urandom_range(60, 66) :
                (r == numlit_pkg::RADIX_HEX) ? $urandom_range(13, 18) : $urandom_range(15, 22);
      else
         ndig = $urandom_range(1, 6);
      if (flaw == 1) ndig = 0;
      for (int i = 0; i < ndig; i++) token_buf.push_back(random_digit(r));
      if (token_buf.size() == 0) token_buf.push_back(8'($urandom_range(0, 255)));
      pos = $urandom_range(0, token_buf.size() - 1);
      if (flaw == 0) token_buf[pos] = 8'($urandom_range(0, 255));
      if (flaw == 2)
         token_buf.insert(pos + 1,
                          $urandom_range(0, 1) ? numlit_pkg::CH_PLUS : numlit_pkg::CH_MINUS);
   endfunction

   task automatic test_plain_forms();
      send_text("0");
      send_text("-9");
      send_text("+7");
      send_text("09");
      send_text("0xaF");
      send_text("0Xf");
      send_text("0b1");
      send_text("0B0");
   endtask

   task automatic test_malformed_tokens();
      send_text("-");
      send_text("+");
      send_text("0x");
      send_text("0b");
      send_text("1-");
      token_buf.delete();
      token_buf.push_back(8'h00);
      send_buffer();
      token_buf.delete();
      token_buf.push_back(8'hFF);
      send_buffer();
   endtask

   task automatic test_saturation();
      send_text("9223372036854775807");
      send_text("9223372036854775808");
      send_text("-9223372036854775808");
      send_text("0x7fffffffffffffff");
      send_text("0X8000000000000000");
      token_buf.delete();
      token_buf.push_back(numlit_pkg::CH_ZERO);
      token_buf.push_back(numlit_pkg::CH_LB);
      repeat (63) token_buf.push_back(numlit_pkg::CH_ONE);
      send_buffer();
      token_buf.delete();
      token_buf.push_back(numlit_pkg::CH_ZERO);
      token_buf.push_back(numlit_pkg::CH_UB);
      token_buf.push_back(numlit_pkg::CH_ONE);
      repeat (63) token_buf.push_back(numlit_pkg::CH_ZERO);
      send_buffer();
   endtask

   task automatic test_random_tokens(input int char_budget, input bit back_to_back);
      int stop_at;
      stop_at = chars_sent + char_budget;
      no_idle = back_to_back;
      while (chars_sent < stop_at) begin
         build_random_token();
         send_buffer();
      end
      no_idle = 1'b0;
   endtask

   always @(posedge clock) begin : drain_pacing
      int n;
      if (reset) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= 0;
      end else if (rsp_valid && rsp_ready) begin
         n = draw_wait();
         hold_cycles <= n;
         rsp_ready   <= (n == 0);
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready   <= (hold_cycles == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      numlit_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result word with nothing expected: value %0d", rsp_data.value);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (want.overflow) saturated_seen++;
            if (rsp_data.value !== want.value) begin
               $error("value: expected %0d, got %0d", want.value, rsp_data.value);
               fail_count++;
            end
            if (rsp_data.radix !== want.radix) begin
               $error("radix: expected %0d, got %0d", want.radix, rsp_data.radix);
               fail_count++;
            end
            if (rsp_data.valid_res !== want.valid_res) begin
               $error("valid_res: expected %0b, got %0b", want.valid_res, rsp_data.valid_res);
               fail_count++;
            end
            if (rsp_data.overflow !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_data.overflow);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      clear_parse_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_plain_forms();
      test_malformed_tokens();
      test_saturation();
      test_random_tokens(250, 1'b1);
      test_random_tokens(1050, 1'b0);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d characters in %0d tokens; checked %0d result words, %0d saturated.",
               chars_sent, tokens_sent, results_checked, saturated_seen);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: sim.f
design/numlit_pkg.sv
design/numlit_step.sv
design/numeric_literal_parser_unit.sv
design/numlit_checker.sv
bench/tb_numeric_literal_parser_unit.sv
